FILE: rtl/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample calibrator package
// Shared widths, codes, reset values and the pipeline tag type.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int OVERSAMPLE_SHIFT = 2;
	localparam int ADC_BITS         = 10;

	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 16;
	localparam int COUNT_W   = 5;
	localparam int GAIN_W    = 18;
	localparam int BIAS_W    = 29;
	localparam int MAX_W     = 12;
	localparam int PROD_W    = GAIN_W + SUM_W + 1;
	localparam int ACC_W     = PROD_W + 2;
	localparam int DIV_SHIFT = 16;
	localparam int CAL_W     = ACC_W - DIV_SHIFT;
	localparam int Y_W       = MAX_W + 2;
	localparam int CFG_W     = BIAS_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [COUNT_W-1:0]  COUNT_FULL = COUNT_W'(1 << OVERSAMPLE_SHIFT);
	localparam logic [SAMPLE_W-1:0] ADC_MASK   = SAMPLE_W'((1 << ADC_BITS) - 1);

	// action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_CHECK  = 2'd1;
	localparam logic [1:0] ACT_REGION = 2'd2;

	// report codes
	localparam logic [1:0] REPORT_NONE    = 2'd0;
	localparam logic [1:0] REPORT_TOUCH   = 2'd1;
	localparam logic [1:0] REPORT_RELEASE = 2'd2;

	// next step codes
	localparam logic [1:0] NEXT_NONE    = 2'd0;
	localparam logic [1:0] NEXT_CONVERT = 2'd1;
	localparam logic [1:0] NEXT_CHECK   = 2'd2;
	localparam logic [1:0] NEXT_WAIT    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_XX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_XY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_YX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_YY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX   = 3'd7;

	localparam logic signed [GAIN_W-1:0] GAIN_XX_RST = 18'sd5171;
	localparam logic signed [GAIN_W-1:0] GAIN_XY_RST = 18'sd9;
	localparam logic signed [BIAS_W-1:0] BIAS_X_RST  = -29'sd17497920;
	localparam logic signed [GAIN_W-1:0] GAIN_YX_RST = -18'sd12;
	localparam logic signed [GAIN_W-1:0] GAIN_YY_RST = -18'sd4659;
	localparam logic signed [BIAS_W-1:0] BIAS_Y_RST  = 29'sd52871808;
	localparam logic [MAX_W-1:0]         X_MAX_RST   = 12'd479;
	localparam logic [MAX_W-1:0]         Y_MAX_RST   = 12'd271;

	localparam logic signed [Y_W-1:0] Y_OFFSET    = 14'sd800;
	localparam logic signed [Y_W-1:0] REGION_STEP = 14'sd272;
	localparam logic signed [Y_W-1:0] Y_HI        = 14'sd2047;
	localparam logic signed [Y_W-1:0] Y_LO        = -14'sd2048;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_SAMPLE,
		KIND_TOUCH,
		KIND_CLEAR,
		KIND_RELEASE,
		KIND_REGION
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] next_step;
	} tag_t;

	function automatic logic signed [MAX_W-1:0] y_clamp(input logic signed [Y_W-1:0] v);
		logic signed [MAX_W-1:0] r;
		if (v > Y_HI) begin
			r = Y_HI[MAX_W-1:0];
		end else if (v < Y_LO) begin
			r = Y_LO[MAX_W-1:0];
		end else begin
			r = v[MAX_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/tsc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample calibrator - accumulator front end
// Takes input items, keeps the oversampling sums and count, classifies the
// item and loads the first pipeline stage.
// ----------------------------------------------------------------------------
module tsc_accum import tsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [SAMPLE_W-1:0] x_sample,
	input  logic [SAMPLE_W-1:0] y_sample,
	input  logic                pen_down,
	input  logic                s2_ready,
	output logic                valid_s1,
	output tag_t                tag_s1,
	output logic [SUM_W-1:0]    sum_x_s1,
	output logic [SUM_W-1:0]    sum_y_s1
);

	logic               s1_ready;
	logic               accept;
	logic [SUM_W-1:0]   sum_x_q;
	logic [SUM_W-1:0]   sum_y_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_inc;
	logic [SUM_W-1:0]   x_add;
	logic [SUM_W-1:0]   y_add;
	tag_t               tag_d;

	assign s1_ready  = !valid_s1 || s2_ready;
	assign in_stall  = !s1_ready;
	assign accept    = in_valid && s1_ready;
	assign count_inc = count_q + 1'b1;
	assign x_add     = SUM_W'(x_sample & ADC_MASK);
	assign y_add     = SUM_W'(y_sample & ADC_MASK);

	always_comb begin
		tag_d.kind      = KIND_NONE;
		tag_d.next_step = NEXT_NONE;
		unique case (action)
			ACT_SAMPLE: begin
				tag_d.kind      = KIND_SAMPLE;
				tag_d.next_step = (count_inc < COUNT_FULL) ? NEXT_CONVERT : NEXT_CHECK;
			end
			ACT_CHECK: begin
				if (pen_down) begin
					tag_d.kind      = (count_q != '0) ? KIND_TOUCH : KIND_CLEAR;
					tag_d.next_step = NEXT_CONVERT;
				end else begin
					tag_d.kind      = KIND_RELEASE;
					tag_d.next_step = NEXT_WAIT;
				end
			end
			ACT_REGION: begin
				tag_d.kind = KIND_REGION;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				unique case (action)
					ACT_SAMPLE: begin
						sum_x_q <= sum_x_q + x_add;
						sum_y_q <= sum_y_q + y_add;
						count_q <= count_inc;
					end
					ACT_CHECK: begin
						// pen up keeps the sums, only the count restarts
						if (pen_down) begin
							sum_x_q <= '0;
							sum_y_q <= '0;
						end
						count_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1   <= tag_d;
			sum_x_s1 <= sum_x_q;
			sum_y_s1 <= sum_y_q;
		end
	end

	a_check_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_CHECK |=> count_q == '0)
		else $error("count not cleared after pen check");

endmodule

FILE: rtl/tsc_calib.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample calibrator - affine calibration
// Stage 2 registers the four weight products, stage 3 adds the bias and
// divides by 65536 with truncation toward zero.
// ----------------------------------------------------------------------------
module tsc_calib import tsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s1,
	input  tag_t                     tag_s1,
	input  logic [SUM_W-1:0]         sum_x_s1,
	input  logic [SUM_W-1:0]         sum_y_s1,
	input  logic signed [GAIN_W-1:0] gain_xx,
	input  logic signed [GAIN_W-1:0] gain_xy,
	input  logic signed [BIAS_W-1:0] bias_x,
	input  logic signed [GAIN_W-1:0] gain_yx,
	input  logic signed [GAIN_W-1:0] gain_yy,
	input  logic signed [BIAS_W-1:0] bias_y,
	input  logic                     out_ready,
	output logic                     s2_ready,
	output logic                     valid_s3,
	output tag_t                     tag_s3,
	output logic signed [CAL_W-1:0]  cal_x_s3,
	output logic signed [CAL_W-1:0]  cal_y_s3
);

	localparam logic signed [ACC_W-1:0] ROUND_IN =
		{{(ACC_W-DIV_SHIFT){1'b0}}, {DIV_SHIFT{1'b1}}};

	logic                     s3_ready;
	logic                     valid_s2;
	tag_t                     tag_s2;
	logic signed [SUM_W:0]    rx;
	logic signed [SUM_W:0]    ry;
	logic signed [PROD_W-1:0] p_xx_d, p_xy_d, p_yx_d, p_yy_d;
	logic signed [PROD_W-1:0] p_xx_s2, p_xy_s2, p_yx_s2, p_yy_s2;
	logic signed [ACC_W-1:0]  acc_x, acc_y;
	logic signed [ACC_W-1:0]  adj_x, adj_y;

	assign s3_ready = !valid_s3 || out_ready;
	assign s2_ready = !valid_s2 || s3_ready;

	assign rx = $signed({1'b0, sum_x_s1});
	assign ry = $signed({1'b0, sum_y_s1});

	assign p_xx_d = gain_xx * rx;
	assign p_xy_d = gain_xy * ry;
	assign p_yx_d = gain_yx * rx;
	assign p_yy_d = gain_yy * ry;

	assign acc_x = {{(ACC_W-BIAS_W){bias_x[BIAS_W-1]}}, bias_x}
		+ {{(ACC_W-PROD_W){p_xx_s2[PROD_W-1]}}, p_xx_s2}
		+ {{(ACC_W-PROD_W){p_xy_s2[PROD_W-1]}}, p_xy_s2};
	assign acc_y = {{(ACC_W-BIAS_W){bias_y[BIAS_W-1]}}, bias_y}
		+ {{(ACC_W-PROD_W){p_yx_s2[PROD_W-1]}}, p_yx_s2}
		+ {{(ACC_W-PROD_W){p_yy_s2[PROD_W-1]}}, p_yy_s2};

	// bias negative values up so the shift truncates toward zero
	assign adj_x = acc_x[ACC_W-1] ? acc_x + ROUND_IN : acc_x;
	assign adj_y = acc_y[ACC_W-1] ? acc_y + ROUND_IN : acc_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (s3_ready) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			tag_s2  <= tag_s1;
			p_xx_s2 <= p_xx_d;
			p_xy_s2 <= p_xy_d;
			p_yx_s2 <= p_yx_d;
			p_yy_s2 <= p_yy_d;
		end
		if (s3_ready && valid_s2) begin
			tag_s3   <= tag_s2;
			cal_x_s3 <= adj_x[ACC_W-1:DIV_SHIFT];
			cal_y_s3 <= adj_y[ACC_W-1:DIV_SHIFT];
		end
	end

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s3_ready |=> valid_s2 && $stable(tag_s2))
		else $error("stage 2 item lost while stage 3 blocked");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |=> valid_s3 && $stable(cal_x_s3) && $stable(cal_y_s3))
		else $error("stage 3 item lost while output blocked");

endmodule

FILE: rtl/tsc_report.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample calibrator - report stage
// Mirrors and clamps the calibrated axes, applies the region offset, tracks
// the last position and the screen region, and holds the output register.
// ----------------------------------------------------------------------------
module tsc_report import tsc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s3,
	input  tag_t                    tag_s3,
	input  logic signed [CAL_W-1:0] cal_x_s3,
	input  logic signed [CAL_W-1:0] cal_y_s3,
	input  logic [MAX_W-1:0]        screen_x_max,
	input  logic [MAX_W-1:0]        screen_y_max,
	input  logic                    out_stall,
	output logic                    out_ready,
	output logic                    out_valid,
	output logic [1:0]              report,
	output logic [MAX_W-1:0]        x_pos,
	output logic signed [MAX_W-1:0] y_pos,
	output logic                    touching,
	output logic [1:0]              next_step
);

	logic                    take;
	logic [MAX_W-1:0]        last_x_q;
	logic [MAX_W-1:0]        last_y_q;
	logic [1:0]              region_q;
	logic signed [CAL_W:0]   x_max_ext, y_max_ext;
	logic signed [CAL_W:0]   dx, dy;
	logic [MAX_W-1:0]        pos_x, pos_y;
	logic                    moved;
	logic signed [Y_W-1:0]   region_ofs;
	logic signed [Y_W-1:0]   touch_y, release_y;
	logic [1:0]              report_d;
	logic [MAX_W-1:0]        x_d;
	logic signed [MAX_W-1:0] y_d;
	logic                    touching_d;

	assign out_ready = !out_valid || !out_stall;
	assign take      = valid_s3 && out_ready;

	// axes swap: screen x comes from calibrated y and the other way round
	assign x_max_ext = $signed({{(CAL_W+1-MAX_W){1'b0}}, screen_x_max});
	assign y_max_ext = $signed({{(CAL_W+1-MAX_W){1'b0}}, screen_y_max});
	assign dx = x_max_ext - {cal_y_s3[CAL_W-1], cal_y_s3};
	assign dy = y_max_ext - {cal_x_s3[CAL_W-1], cal_x_s3};

	always_comb begin
		if (dx[CAL_W]) begin
			pos_x = '0;
		end else if (dx > x_max_ext) begin
			pos_x = screen_x_max;
		end else begin
			pos_x = dx[MAX_W-1:0];
		end
		if (dy[CAL_W]) begin
			pos_y = '0;
		end else if (dy > y_max_ext) begin
			pos_y = screen_y_max;
		end else begin
			pos_y = dy[MAX_W-1:0];
		end
	end

	assign moved = (pos_x != last_x_q) || (pos_y != last_y_q);

	always_comb begin
		unique case (region_q)
			2'd0: region_ofs = '0;
			2'd1: region_ofs = REGION_STEP;
			2'd2: region_ofs = REGION_STEP + REGION_STEP;
			2'd3: region_ofs = REGION_STEP + REGION_STEP + REGION_STEP;
		endcase
	end

	assign touch_y   = $signed({2'b00, pos_y}) + Y_OFFSET - region_ofs;
	assign release_y = $signed({2'b00, last_y_q}) + Y_OFFSET;

	always_comb begin
		report_d   = REPORT_NONE;
		x_d        = '0;
		y_d        = '0;
		touching_d = 1'b0;
		unique case (tag_s3.kind)
			KIND_TOUCH: begin
				if (moved) begin
					report_d   = REPORT_TOUCH;
					x_d        = pos_x;
					y_d        = y_clamp(touch_y);
					touching_d = 1'b1;
				end
			end
			KIND_RELEASE: begin
				report_d = REPORT_RELEASE;
				x_d      = last_x_q;
				y_d      = y_clamp(release_y);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q  <= '0;
			last_y_q  <= '0;
			region_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid <= valid_s3;
			end
			if (take) begin
				unique case (tag_s3.kind)
					KIND_TOUCH: begin
						last_x_q <= pos_x;
						last_y_q <= pos_y;
					end
					KIND_REGION: begin
						// wraps from the last region back to the first
						region_q <= region_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			report    <= report_d;
			x_pos     <= x_d;
			y_pos     <= y_d;
			touching  <= touching_d;
			next_step <= tag_s3.next_step;
		end
	end

	a_touch_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> touching == (report == REPORT_TOUCH))
		else $error("touch flag disagrees with report code");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report == REPORT_NONE |-> x_pos == '0 && y_pos == '0)
		else $error("position driven without a report");

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report == REPORT_TOUCH |-> x_pos <= screen_x_max)
		else $error("reported x beyond screen maximum");

endmodule

FILE: rtl/touch_sample_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch sample calibrator
// Resistive touchscreen front end: oversampled X/Y sums, affine calibration,
// axis swap and mirror, clamp, region offset and touch/release reports.
// ----------------------------------------------------------------------------
// Usage: drive an item on action/x_sample/y_sample/pen_down with in_valid; it
// is taken at an edge where in_stall is low. Every item yields one result on
// report/x_pos/y_pos/touching/next_step, taken at an edge where out_valid is
// high and out_stall is low.
// The item passes through the input stage, the product stage, the calibration
// stage and then the output register. One item is taken every cycle while
// in_stall is low; the four 18x17 bit products of stage 2 set the clock
// period.
// A stalled receiver holds the output register; stages behind it keep filling
// bubbles, and in_stall rises only once every stage holds an item.
// Reset clears sums, count, last position, screen region and all valid flags,
// and loads calibration defaults. The user writes configuration through
// cfg_write/cfg_index/cfg_data while no item is in flight; not enforced.
// ----------------------------------------------------------------------------
module touch_sample_calibrator import tsc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [SAMPLE_W-1:0]     x_sample,
	input  logic [SAMPLE_W-1:0]     y_sample,
	input  logic                    pen_down,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              report,
	output logic [MAX_W-1:0]        x_pos,
	output logic signed [MAX_W-1:0] y_pos,
	output logic                    touching,
	output logic [1:0]              next_step
);

	logic signed [GAIN_W-1:0] gain_xx_q, gain_xy_q, gain_yx_q, gain_yy_q;
	logic signed [BIAS_W-1:0] bias_x_q, bias_y_q;
	logic [MAX_W-1:0]         x_max_q, y_max_q;

	logic                    s2_ready;
	logic                    out_ready;
	logic                    valid_s1;
	tag_t                    tag_s1;
	logic [SUM_W-1:0]        sum_x_s1, sum_y_s1;
	logic                    valid_s3;
	tag_t                    tag_s3;
	logic signed [CAL_W-1:0] cal_x_s3, cal_y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_xx_q <= GAIN_XX_RST;
			gain_xy_q <= GAIN_XY_RST;
			bias_x_q  <= BIAS_X_RST;
			gain_yx_q <= GAIN_YX_RST;
			gain_yy_q <= GAIN_YY_RST;
			bias_y_q  <= BIAS_Y_RST;
			x_max_q   <= X_MAX_RST;
			y_max_q   <= Y_MAX_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GAIN_XX: gain_xx_q <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_XY: gain_xy_q <= $signed(cfg_data[GAIN_W-1:0]);
				REG_BIAS_X:  bias_x_q  <= $signed(cfg_data[BIAS_W-1:0]);
				REG_GAIN_YX: gain_yx_q <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_YY: gain_yy_q <= $signed(cfg_data[GAIN_W-1:0]);
				REG_BIAS_Y:  bias_y_q  <= $signed(cfg_data[BIAS_W-1:0]);
				REG_X_MAX:   x_max_q   <= cfg_data[MAX_W-1:0];
				REG_Y_MAX:   y_max_q   <= cfg_data[MAX_W-1:0];
			endcase
		end
	end

	tsc_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.x_sample (x_sample),
		.y_sample (y_sample),
		.pen_down (pen_down),
		.s2_ready (s2_ready),
		.valid_s1 (valid_s1),
		.tag_s1   (tag_s1),
		.sum_x_s1 (sum_x_s1),
		.sum_y_s1 (sum_y_s1)
	);

	tsc_calib u_calib (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.tag_s1    (tag_s1),
		.sum_x_s1  (sum_x_s1),
		.sum_y_s1  (sum_y_s1),
		.gain_xx   (gain_xx_q),
		.gain_xy   (gain_xy_q),
		.bias_x    (bias_x_q),
		.gain_yx   (gain_yx_q),
		.gain_yy   (gain_yy_q),
		.bias_y    (bias_y_q),
		.out_ready (out_ready),
		.s2_ready  (s2_ready),
		.valid_s3  (valid_s3),
		.tag_s3    (tag_s3),
		.cal_x_s3  (cal_x_s3),
		.cal_y_s3  (cal_y_s3)
	);

	tsc_report u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s3     (valid_s3),
		.tag_s3       (tag_s3),
		.cal_x_s3     (cal_x_s3),
		.cal_y_s3     (cal_y_s3),
		.screen_x_max (x_max_q),
		.screen_y_max (y_max_q),
		.out_stall    (out_stall),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.report       (report),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.touching     (touching),
		.next_step    (next_step)
	);

endmodule
